FILE: sv/ler_pkg.sv
// Shared constants and the saturating add for the emission-rate block.
// No dependencies.
package ler_pkg;

    localparam int SLOTS        = 6;
    localparam int SERIES_TERMS = 22;

    // ln 2 in Q.56 and 1/ln 2 in Q.24
    localparam logic [63:0]        LN2_Q56     = 64'h00B17217F7D1CF7A;
    localparam logic signed [25:0] INV_LN2_Q24 = 26'sd24204406;

    localparam logic signed [63:0] E_MAX   = 64'sd268435455;
    localparam logic signed [63:0] E_MIN   = -64'sd268435456;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;
    localparam logic [62:0]        TOTAL_MAX = '1;
    localparam logic [31:0]        EXP_MAX   = '1;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

endpackage

FILE: sv/log_linear_emission_rate.sv
// Top level of the log-linear emission-rate block: coefficient RAM, sequencer and datapath.
// Depends on ler_pkg and ler_ram.
//
// Usage:
//   Input stream (s_axis): tuser carries the mode, 0 loads one coefficient and 1 evaluates
//   a road segment. tdata carries class, slot, coefficient and the segment fields.
//   A load produces no output transfer; loads to slot 6 or 7 or to a
//   class at or above ROAD_CLASSES are dropped. An evaluate produces one output transfer.
//   Output stream (m_axis): tdata carries amount and running total, tuser the saturated flag.
//   An evaluate runs from input transfer to output valid in these steps: a coefficient read
//   and multiply per slot (with a second multiply for the squared-speed term), range
//   reduction, then 22 series steps (four 32x32 partial products on one shared
//   multiplier, a rounding step, an 8-bit-per-cycle divide by the step index, an update),
//   and the final scale and total.
//   One item is in flight at a time; s_axis tready is high only while the block is idle.
//   The result sits in an output register, so a new item is taken while it waits; if an
//   evaluate finishes while the previous result is still held, it waits for that transfer.
//   Reset clears the coefficient valid bits (all coefficients read as zero), the running
//   total and the output valid.
module log_linear_emission_rate #(
    parameter int ROAD_CLASSES = 8,
    parameter int COEF_BITS    = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // road_class[2:0], coef_slot[5:3], coef_value[37:6], speed[53:38], gradient[69:54],
    // traffic[85:70], fill[101:86], seg_length[121:102], zero pad[127:122]
    input  logic [127:0] i_s_axis_tdata,
    // mode[0]
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // amount[47:0], running_total[110:48], zero pad[111]
    output logic [111:0] o_m_axis_tdata,
    // saturated[0]
    output logic         o_m_axis_tuser
);

    localparam int DEPTH = ROAD_CLASSES * ler_pkg::SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = COEF_BITS;
    localparam logic signed [65:0] LN2_S = 66'(ler_pkg::LN2_Q56);

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_MUL, S_TERM, S_ADD, S_CLAMP, S_EST, S_REM, S_FIX,
        S_PP, S_PPACC, S_RND, S_DIV, S_UPD, S_SHIFT, S_AMT, S_TOT
    } t_state;

    t_state r_state;

    // input fields
    logic [2:0]         in_cls;
    logic [2:0]         in_slot;
    logic signed [31:0] in_coef;
    logic [15:0]        in_speed;
    logic accept;

    assign in_cls   = i_s_axis_tdata[2:0];
    assign in_slot  = i_s_axis_tdata[5:3];
    assign in_coef  = i_s_axis_tdata[37:6];
    assign in_speed = i_s_axis_tdata[53:38];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // item registers
    logic [2:0]         r_cls;
    logic [15:0]        r_s;
    logic signed [15:0] r_g;
    logic [15:0]        r_t;
    logic [15:0]        r_f;
    logic [19:0]        r_len;
    logic [31:0]        r_sq;

    // exponent accumulation
    logic [2:0]            r_slot;
    logic                  r_sub;
    logic                  r_cok;
    logic signed [CB-1:0]  r_coef;
    logic signed [63:0]    r_prod;
    logic signed [63:0]    r_term;
    logic signed [63:0]    r_e;
    logic                  r_flag;

    // range reduction and series
    logic signed [28:0]  r_e29;
    logic signed [54:0]  r_nprod;
    logic signed [7:0]   r_n;
    logic signed [65:0]  r_r;
    logic [61:0]         r_rr;
    logic [62:0]         r_tm;
    logic [63:0]         r_sum;
    logic [4:0]          r_k;
    logic [1:0]          r_pp_idx;
    logic [63:0]         r_pp;
    logic [125:0]        r_acc;
    logic [63:0]         r_dvd;
    logic [4:0]          r_rem;
    logic [2:0]          r_dcnt;
    logic [31:0]         r_q;
    logic [51:0]         r_aprod;

    // output
    logic        r_out_valid;
    logic [47:0] r_out_amount;
    logic [62:0] r_out_total;
    logic        r_out_sat;
    logic [62:0] r_total;

    // coefficient memory and valid bits
    logic [DEPTH-1:0] r_cvalid;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [CB-1:0]    ram_rdata;
    logic [5:0]       waddr_full;
    logic [5:0]       raddr_full;
    logic [AW+5:0]    waddr_wide;
    logic [AW+5:0]    raddr_wide;
    logic             in_cls_ok;
    logic             r_cls_ok;

    assign in_cls_ok  = (32'(in_cls) < ROAD_CLASSES);
    assign r_cls_ok   = (32'(r_cls) < ROAD_CLASSES);
    assign waddr_full = 6'(in_cls) * 6'(ler_pkg::SLOTS) + 6'(in_slot);
    assign raddr_full = 6'(r_cls) * 6'(ler_pkg::SLOTS) + 6'(r_slot);
    assign waddr_wide = (AW + 6)'(waddr_full);
    assign raddr_wide = (AW + 6)'(raddr_full);
    assign ram_waddr  = waddr_wide[AW-1:0];
    assign ram_raddr  = raddr_wide[AW-1:0];
    assign ram_we     = accept && !i_s_axis_tuser && in_cls_ok &&
                        (32'(in_slot) < ler_pkg::SLOTS);

    ler_ram #(
        .WIDTH (CB),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (CB'(in_coef)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // term multiply operand and shift
    logic signed [CB-1:0] coef_cur;
    logic signed [16:0]   op17;
    logic [4:0]           shamt;
    logic signed [CB+16:0] prod_full;
    logic signed [63:0]   shifted;

    assign coef_cur  = r_sub ? r_coef : (r_cok ? $signed(ram_rdata) : '0);
    assign prod_full = coef_cur * op17;
    assign shifted   = r_prod >>> shamt;

    always_comb begin
        op17  = 17'sd1;
        shamt = 5'd0;
        case (r_slot)
            3'd1: begin
                op17  = $signed({1'b0, r_s});
                shamt = 5'd8;
            end
            3'd2: begin
                op17  = r_sub ? $signed({1'b0, r_sq[15:0]}) : $signed({1'b0, r_sq[31:16]});
                shamt = r_sub ? 5'd16 : 5'd0;
            end
            3'd3: begin
                op17  = {r_g[15], r_g};
                shamt = 5'd12;
            end
            3'd4: begin
                op17  = $signed({1'b0, r_t});
                shamt = 5'd8;
            end
            3'd5: begin
                op17  = $signed({1'b0, r_f});
                shamt = 5'd16;
            end
            default: begin
                op17  = 17'sd1;
                shamt = 5'd0;
            end
        endcase
    end

    // range reduction
    logic signed [7:0]  n0;
    logic signed [65:0] x_val;
    logic signed [65:0] nl;
    logic signed [65:0] r_fixed;
    logic signed [7:0]  n_fixed;

    assign n0    = {r_nprod[54], r_nprod[54:48]};
    assign x_val = 66'(r_e29) <<< 32;
    assign nl    = n0 * LN2_S;

    always_comb begin
        r_fixed = r_r;
        n_fixed = r_n;
        if (r_r < 0) begin
            r_fixed = r_r + LN2_S;
            n_fixed = r_n - 8'sd1;
        end else if (r_r >= LN2_S) begin
            r_fixed = r_r - LN2_S;
            n_fixed = r_n + 8'sd1;
        end
    end

    // partial products of term * R
    logic [31:0]  pp_a;
    logic [31:0]  pp_b;
    logic [125:0] pp_shifted;

    assign pp_a = r_pp_idx[0] ? {1'b0, r_tm[62:32]} : r_tm[31:0];
    assign pp_b = r_pp_idx[1] ? {2'b0, r_rr[61:32]} : r_rr[31:0];

    always_comb begin
        case (r_pp_idx)
            2'd0:    pp_shifted = 126'(r_pp);
            2'd3:    pp_shifted = 126'(r_pp) << 64;
            default: pp_shifted = 126'(r_pp) << 32;
        endcase
    end

    // eight restoring-division steps per cycle by the series index
    logic [63:0] div_q;
    logic [4:0]  div_rem;

    always_comb begin
        logic [5:0] rem2;
        div_q   = r_dvd;
        div_rem = r_rem;
        for (int j = 0; j < 8; j++) begin
            rem2  = {div_rem, div_q[63]};
            div_q = {div_q[62:0], 1'b0};
            if (rem2 >= {1'b0, r_k}) begin
                rem2     = rem2 - {1'b0, r_k};
                div_q[0] = 1'b1;
            end
            div_rem = rem2[4:0];
        end
    end

    // final scaling to Q16.16
    logic signed [8:0] sh9;
    logic [5:0]        sh;
    logic [64:0]       rnd_val;
    logic [64:0]       q65;

    assign sh9     = 9'sd46 - 9'(r_n);
    assign sh      = sh9[5:0];
    assign rnd_val = {1'b0, r_sum} + (65'd1 << (sh - 6'd1));
    assign q65     = (sh9 > 9'sd63) ? 65'd0 : (rnd_val >> sh);

    // amount and total
    logic [52:0] amt_rnd;
    logic [47:0] amount;
    logic [63:0] tot_sum;
    logic        out_free;

    assign amt_rnd  = (53'(r_aprod) + 53'd8) >> 4;
    assign amount   = amt_rnd[47:0];
    assign tot_sum  = {1'b0, r_total} + 64'(amount);
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cvalid    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the final state loads the output register itself
            if (r_out_valid && i_m_axis_tready && r_state != S_TOT) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_cvalid[ram_waddr] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_s_axis_tuser) begin
                        r_cls  <= in_cls;
                        r_s    <= in_speed;
                        r_g    <= i_s_axis_tdata[69:54];
                        r_t    <= i_s_axis_tdata[85:70];
                        r_f    <= i_s_axis_tdata[101:86];
                        r_len  <= i_s_axis_tdata[121:102];
                        r_sq   <= in_speed * in_speed;
                        r_slot <= 3'd0;
                        r_sub  <= 1'b0;
                        r_e    <= '0;
                        r_term <= '0;
                        r_flag <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_cok   <= r_cls_ok && r_cvalid[ram_raddr];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_coef  <= coef_cur;
                    r_prod  <= 64'(prod_full);
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    if (r_slot == 3'd2 && r_sub) begin
                        r_term <= ler_pkg::sat_add(r_term, shifted);
                    end else begin
                        r_term <= shifted;
                    end
                    if (r_slot == 3'd2 && !r_sub) begin
                        r_sub   <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_e   <= ler_pkg::sat_add(r_e, r_term);
                    r_sub <= 1'b0;
                    if (r_slot == 3'(ler_pkg::SLOTS - 1)) begin
                        r_state <= S_CLAMP;
                    end else begin
                        r_slot  <= r_slot + 3'd1;
                        r_state <= S_RD;
                    end
                end
                S_CLAMP: begin
                    if (r_e > ler_pkg::E_MAX) begin
                        r_e29  <= 29'(ler_pkg::E_MAX);
                        r_flag <= 1'b1;
                    end else if (r_e < ler_pkg::E_MIN) begin
                        r_e29  <= 29'(ler_pkg::E_MIN);
                        r_flag <= 1'b1;
                    end else begin
                        r_e29 <= r_e[28:0];
                    end
                    r_state <= S_EST;
                end
                S_EST: begin
                    r_nprod <= r_e29 * ler_pkg::INV_LN2_Q24;
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_n     <= n0;
                    r_r     <= x_val - nl;
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    // estimate is off by at most one step of ln 2
                    r_n      <= n_fixed;
                    r_rr     <= {r_fixed[55:0], 6'd0};
                    r_tm     <= 63'd1 << 62;
                    r_sum    <= 64'd1 << 62;
                    r_k      <= 5'd1;
                    r_pp_idx <= 2'd0;
                    r_acc    <= '0;
                    r_state  <= S_PP;
                end
                S_PP: begin
                    r_pp    <= pp_a * pp_b;
                    r_state <= S_PPACC;
                end
                S_PPACC: begin
                    r_acc    <= r_acc + pp_shifted;
                    r_pp_idx <= r_pp_idx + 2'd1;
                    r_state  <= (r_pp_idx == 2'd3) ? S_RND : S_PP;
                end
                S_RND: begin
                    r_dvd   <= 64'((r_acc + (126'd1 << 61)) >> 62);
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dvd  <= div_q;
                    r_rem  <= div_rem;
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'd7) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_tm  <= r_dvd[62:0];
                    r_sum <= r_sum + r_dvd;
                    if (r_k == 5'(ler_pkg::SERIES_TERMS)) begin
                        r_state <= S_SHIFT;
                    end else begin
                        r_k      <= r_k + 5'd1;
                        r_pp_idx <= 2'd0;
                        r_acc    <= '0;
                        r_state  <= S_PP;
                    end
                end
                S_SHIFT: begin
                    if (q65 > 65'(ler_pkg::EXP_MAX)) begin
                        r_q    <= ler_pkg::EXP_MAX;
                        r_flag <= 1'b1;
                    end else begin
                        r_q <= q65[31:0];
                    end
                    r_state <= S_AMT;
                end
                S_AMT: begin
                    r_aprod <= r_q * r_len;
                    r_state <= S_TOT;
                end
                S_TOT: begin
                    // hold until the previous result has been taken
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_amount <= amount;
                        if (tot_sum[63]) begin
                            r_total     <= ler_pkg::TOTAL_MAX;
                            r_out_total <= ler_pkg::TOTAL_MAX;
                            r_out_sat   <= 1'b1;
                        end else begin
                            r_total     <= tot_sum[62:0];
                            r_out_total <= tot_sum[62:0];
                            r_out_sat   <= r_flag;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_total, r_out_amount};
    assign o_m_axis_tuser  = r_out_sat;

endmodule

FILE: sv/ler_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ler_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
